// ===== sv/rwst_pkg.sv =====
package rwst_pkg;

  // field widths fixed by the item format
  localparam int RSSI_W      = 8;
  localparam int TH_W        = 7;
  localparam int CNT_OUT_W   = 7;
  localparam int OUT_TDATA_W = 40;

  // reset and limit values
  localparam logic [TH_W-1:0]          TH_RESET        = 7'd5;
  localparam logic signed [RSSI_W-1:0] INVALID_LIMIT   = -8'sd127;
  localparam logic signed [RSSI_W-1:0] MAX_RESET       = -8'sd127;
  localparam int                       TREND_MIN_COUNT = 3;

  // trend codes
  typedef enum logic [1:0] {
    TREND_UNKNOWN   = 2'd0,
    TREND_STABLE    = 2'd1,
    TREND_IMPROVING = 2'd2,
    TREND_WORSENING = 2'd3
  } trend_t;

endpackage

// ===== sv/rwst_ring.sv =====
module rwst_ring #(
  parameter int DEPTH = 64,
  parameter int PTR_W = 6
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [PTR_W-1:0]                 wr_addr,
  input  logic signed [rwst_pkg::RSSI_W-1:0] wr_data,
  input  logic                             rd_en,
  input  logic [PTR_W-1:0]                 rd_addr,
  output logic signed [rwst_pkg::RSSI_W-1:0] rd_data
);
  import rwst_pkg::*;

  logic signed [RSSI_W-1:0] mem [DEPTH];
  logic signed [RSSI_W-1:0] rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/rwst_div.sv =====
module rwst_div #(
  parameter int SUM_W = 15,
  parameter int CNT_W = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [SUM_W-1:0]           dividend,
  input  logic [CNT_W-1:0]                  divisor,
  output logic                              done,
  output logic signed [rwst_pkg::RSSI_W-1:0] quot
);
  import rwst_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  logic                    busy_r;
  logic                    done_r;
  logic [STEP_W-1:0]       step_r;
  logic [SUM_W-1:0]        mag_r;
  logic [CNT_W-1:0]        rem_r;
  logic [SUM_W-1:0]        q_r;
  logic                    neg_r;
  logic [CNT_W-1:0]        d_r;
  logic signed [RSSI_W-1:0] quot_r;

  logic [CNT_W:0]   rem_t;
  logic             ge;
  logic [CNT_W:0]   rem_s;
  logic [SUM_W-1:0] q_new;
  logic [SUM_W-1:0] q_signed;
  logic [SUM_W-1:0] mag_in;

  // one restoring step per cycle on the magnitude
  always_comb begin
    rem_t    = {rem_r, mag_r[SUM_W-1]};
    ge       = (rem_t >= {1'b0, d_r});
    rem_s    = ge ? (rem_t - {1'b0, d_r}) : rem_t;
    q_new    = {q_r[SUM_W-2:0], ge};
    q_signed = neg_r ? (~q_new + 1'b1) : q_new;
    mag_in   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        mag_r  <= mag_in;
        rem_r  <= '0;
        q_r    <= '0;
        neg_r  <= dividend[SUM_W-1];
        d_r    <= divisor;
      end else if (busy_r) begin
        mag_r  <= {mag_r[SUM_W-2:0], 1'b0};
        rem_r  <= rem_s[CNT_W-1:0];
        q_r    <= q_new;
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quot_r <= q_signed[RSSI_W-1:0];
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== sv/rssi_window_stats_trend.sv =====
// channel | direction | handshake               | payload
// in      | input     | in_tvalid / in_tready   | tuser: action; tdata: rssi
// out     | output    | out_tvalid / out_tready | tdata: mean, lowest, highest, trend, count
// cfg     | input     | cfg_wr_en               | cfg_wr_data: trend_threshold
//
// a record transaction runs a scan over the single ring read port, then up to three
// bit-serial divisions on a shared divider of SUM_W steps. a clear skips the scan
// and the divisions.
// rst_n is synchronous: it empties the ring logically and loads the statistic reset values.
// a new transaction is taken while a result waits in the output stage until out_tready;
// a finished result waits in ST_OUT while that stage is full, and input is held off then.
module rssi_window_stats_trend #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [0:0]                        in_tuser,   // [0] action
  input  logic [7:0]                        in_tdata,   // [7:0] rssi
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] mean_level, [15:8] lowest_level, [23:16] highest_level,
  // [25:24] trend_code, [32:26] stored_count, [39:33] zero
  output logic [rwst_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [rwst_pkg::TH_W-1:0]         cfg_wr_data  // trend_threshold
);
  import rwst_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = RSSI_W + CNT_W;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] MIN_CNT  = CNT_W'(TREND_MIN_COUNT);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DIVM, ST_DIVR, ST_DIVO, ST_TREND, ST_OUT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [PTR_W-1:0]         wp_r, wp_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [PTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]         issue_r, issue_nxt;
  logic                     pend_r, pend_nxt;
  logic [CNT_W-1:0]         pend_i_r, pend_i_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [SUM_W-1:0]  recent_r, recent_nxt;
  logic signed [SUM_W-1:0]  older_r, older_nxt;
  logic [CNT_W-1:0]         vcnt_r, vcnt_nxt;
  logic signed [RSSI_W-1:0] lo_r, lo_nxt;
  logic signed [RSSI_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0]         half_r, half_nxt;
  logic signed [RSSI_W-1:0] mean_r, mean_nxt;
  logic signed [RSSI_W-1:0] min_r, min_nxt;
  logic signed [RSSI_W-1:0] max_r, max_nxt;
  trend_t                   trend_r, trend_nxt;
  logic signed [RSSI_W-1:0] qrec_r, qrec_nxt;
  logic signed [RSSI_W-1:0] qold_r, qold_nxt;
  logic                     launched_r, launched_nxt;
  logic [TH_W-1:0]          th_r;
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]   out_tdata_r, out_tdata_nxt;

  logic                     in_acc;
  logic                     ring_wr;
  logic                     ring_rd;
  logic signed [RSSI_W-1:0] ring_q;
  logic                     div_start;
  logic signed [SUM_W-1:0]  div_dividend;
  logic [CNT_W-1:0]         div_divisor;
  logic                     div_done;
  logic signed [RSSI_W-1:0] div_quot;
  logic [CNT_W-1:0]         fill_inc;
  logic [CNT_W-1:0]         twice_half;
  logic signed [SUM_W-1:0]  s_ext;
  logic signed [RSSI_W:0]   diff;
  logic signed [RSSI_W:0]   th_s;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_wide;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign ring_wr   = in_acc && !in_tuser[0];
  assign ring_rd   = (state_r == ST_SCAN) && (issue_r != fill_r);

  rwst_ring #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr),
    .wr_addr (wp_r),
    .wr_data (in_tdata),
    .rd_en   (ring_rd),
    .rd_addr (rd_ptr_r),
    .rd_data (ring_q)
  );

  rwst_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  // divider operand selection
  always_comb begin
    case (state_r)
      ST_DIVM: begin
        div_dividend = sum_r;
        div_divisor  = vcnt_r;
      end
      ST_DIVR: begin
        div_dividend = recent_r;
        div_divisor  = half_r;
      end
      default: begin
        div_dividend = older_r;
        div_divisor  = half_r;
      end
    endcase
  end

  assign fill_inc   = (fill_r == DEPTH_C) ? fill_r : (fill_r + 1'b1);
  assign twice_half = {half_r[CNT_W-2:0], 1'b0};
  assign s_ext      = {{(SUM_W-RSSI_W){ring_q[RSSI_W-1]}}, ring_q};
  assign diff       = {qrec_r[RSSI_W-1], qrec_r} - {qold_r[RSSI_W-1], qold_r};
  assign th_s       = {2'b00, th_r};
  assign cnt_wide   = {{CNT_OUT_W{1'b0}}, fill_r};

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    fill_nxt       = fill_r;
    rd_ptr_nxt     = rd_ptr_r;
    issue_nxt      = issue_r;
    pend_nxt       = 1'b0;
    pend_i_nxt     = issue_r;
    sum_nxt        = sum_r;
    recent_nxt     = recent_r;
    older_nxt      = older_r;
    vcnt_nxt       = vcnt_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    half_nxt       = half_r;
    mean_nxt       = mean_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    trend_nxt      = trend_r;
    qrec_nxt       = qrec_r;
    qold_nxt       = qold_r;
    launched_nxt   = launched_r;
    div_start      = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0]) begin
            // clear: pointer, count and statistics back to reset values
            wp_nxt    = '0;
            fill_nxt  = '0;
            mean_nxt  = '0;
            min_nxt   = '0;
            max_nxt   = MAX_RESET;
            trend_nxt = TREND_UNKNOWN;
            state_nxt = ST_OUT;
          end else begin
            // record: sample goes in at the write pointer this cycle
            wp_nxt     = (wp_r == LAST_PTR) ? '0 : (wp_r + 1'b1);
            fill_nxt   = fill_inc;
            half_nxt   = {1'b0, fill_inc[CNT_W-1:1]};
            rd_ptr_nxt = wp_r;
            issue_nxt  = '0;
            sum_nxt    = '0;
            recent_nxt = '0;
            older_nxt  = '0;
            vcnt_nxt   = '0;
            lo_nxt     = '0;
            hi_nxt     = MAX_RESET;
            state_nxt  = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // walk newest to oldest, one read issued per cycle
        if (ring_rd) begin
          rd_ptr_nxt = (rd_ptr_r == '0) ? LAST_PTR : (rd_ptr_r - 1'b1);
          issue_nxt  = issue_r + 1'b1;
          pend_nxt   = 1'b1;
        end
        // fold in the sample read last cycle
        if (pend_r) begin
          if (ring_q > INVALID_LIMIT) begin
            sum_nxt  = sum_r + s_ext;
            vcnt_nxt = vcnt_r + 1'b1;
            if ((vcnt_r == '0) || (ring_q < lo_r)) begin
              lo_nxt = ring_q;
            end
            if (ring_q > hi_r) begin
              hi_nxt = ring_q;
            end
          end
          if (pend_i_r < half_r) begin
            recent_nxt = recent_r + s_ext;
          end else if (pend_i_r < twice_half) begin
            older_nxt = older_r + s_ext;
          end
        end
        if (!ring_rd && !pend_r) begin
          if (vcnt_r != '0) begin
            min_nxt   = lo_r;
            max_nxt   = hi_r;
            state_nxt = ST_DIVM;
          end else if (fill_r >= MIN_CNT) begin
            state_nxt = ST_DIVR;
          end else begin
            state_nxt = ST_TREND;
          end
        end
      end

      ST_DIVM, ST_DIVR, ST_DIVO: begin
        if (!launched_r) begin
          div_start    = 1'b1;
          launched_nxt = 1'b1;
        end else if (div_done) begin
          launched_nxt = 1'b0;
          case (state_r)
            ST_DIVM: begin
              mean_nxt  = div_quot;
              state_nxt = (fill_r >= MIN_CNT) ? ST_DIVR : ST_TREND;
            end
            ST_DIVR: begin
              qrec_nxt  = div_quot;
              state_nxt = ST_DIVO;
            end
            default: begin
              qold_nxt  = div_quot;
              state_nxt = ST_TREND;
            end
          endcase
        end
      end

      ST_TREND: begin
        // half-window mean difference against the threshold; unknown below TREND_MIN_COUNT samples
        if (fill_r < MIN_CNT) begin
          trend_nxt = TREND_UNKNOWN;
        end else if (diff > th_s) begin
          trend_nxt = TREND_IMPROVING;
        end else if (diff < -th_s) begin
          trend_nxt = TREND_WORSENING;
        end else begin
          trend_nxt = TREND_STABLE;
        end
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        // load the output stage once it is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{(OUT_TDATA_W-33){1'b0}}, cnt_wide[CNT_OUT_W-1:0], trend_r,
                            max_r, min_r, mean_r};
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wp_r         <= '0;
      fill_r       <= '0;
      pend_r       <= 1'b0;
      launched_r   <= 1'b0;
      mean_r       <= '0;
      min_r        <= '0;
      max_r        <= MAX_RESET;
      trend_r      <= TREND_UNKNOWN;
      th_r         <= TH_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wp_r         <= wp_nxt;
      fill_r       <= fill_nxt;
      pend_r       <= pend_nxt;
      launched_r   <= launched_nxt;
      mean_r       <= mean_nxt;
      min_r        <= min_nxt;
      max_r        <= max_nxt;
      trend_r      <= trend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        th_r <= cfg_wr_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_ptr_r    <= rd_ptr_nxt;
    issue_r     <= issue_nxt;
    pend_i_r    <= pend_i_nxt;
    sum_r       <= sum_nxt;
    recent_r    <= recent_nxt;
    older_r     <= older_nxt;
    vcnt_r      <= vcnt_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    half_r      <= half_nxt;
    qrec_r      <= qrec_nxt;
    qold_r      <= qold_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
